// ----- rtl/hcbd_pkg.sv -----
// Shared constants and types for the HTTP chunked body decoder.
// Holds phase and status codes, character codes and the hex digit decoder.
// No dependencies.
package hcbd_pkg;

  localparam int PhaseW  = 4;
  localparam int StatusW = 2;

  // parser phases
  localparam logic [PhaseW-1:0] PH_LINE    = 4'd0;
  localparam logic [PhaseW-1:0] PH_LINE_CR = 4'd1;
  localparam logic [PhaseW-1:0] PH_EXT     = 4'd2;
  localparam logic [PhaseW-1:0] PH_EXT_CR  = 4'd3;
  localparam logic [PhaseW-1:0] PH_DATA    = 4'd4;
  localparam logic [PhaseW-1:0] PH_DATA_CR = 4'd5;
  localparam logic [PhaseW-1:0] PH_DATA_LF = 4'd6;
  localparam logic [PhaseW-1:0] PH_DONE    = 4'd7;
  localparam logic [PhaseW-1:0] PH_ERROR   = 4'd8;

  localparam logic [StatusW-1:0] ST_RUNNING  = 2'd0;
  localparam logic [StatusW-1:0] ST_COMPLETE = 2'd1;
  localparam logic [StatusW-1:0] ST_ERROR    = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic               data_valid;
    logic [7:0]         data_byte;
    logic [StatusW-1:0] status;
  } hcbd_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hcbd_hex_t;

  function automatic hcbd_hex_t hex_decode(input logic [7:0] ch);
    hcbd_hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      h.value = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      h.value = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      h.value = 4'(ch - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- rtl/hcbd_step.sv -----
// Next-state and result logic of the chunked body parser for one byte.
// Purely combinational; uses hcbd_pkg.
module hcbd_step #(
  parameter int SIZE_BITS = 32
) (
  input  logic [hcbd_pkg::PhaseW-1:0] phase_i,
  input  logic [SIZE_BITS-1:0]        acc_i,
  input  logic [SIZE_BITS-1:0]        left_i,
  input  logic                        seen_i,
  input  logic                        started_i,
  input  logic [7:0]                  byte_i,
  input  logic                        last_i,
  output logic [hcbd_pkg::PhaseW-1:0] phase_o,
  output logic [SIZE_BITS-1:0]        acc_o,
  output logic [SIZE_BITS-1:0]        left_o,
  output logic                        seen_o,
  output logic                        started_o,
  output hcbd_pkg::hcbd_result_t      res_o
);
  import hcbd_pkg::*;

  hcbd_hex_t            hex;
  logic [SIZE_BITS-1:0] left_dec;

  assign hex      = hex_decode(byte_i);
  assign left_dec = left_i - SIZE_BITS'(1);

  always_comb begin
    phase_o          = phase_i;
    acc_o            = acc_i;
    left_o           = left_i;
    seen_o           = seen_i;
    started_o        = started_i;
    res_o.data_valid = 1'b0;
    res_o.data_byte  = 8'd0;
    res_o.status     = ST_RUNNING;

    unique case (phase_i)
      PH_LINE: begin
        started_o = 1'b1;
        if (byte_i == CH_SPACE || byte_i == CH_TAB) begin
          phase_o = PH_LINE;
        end else if (hex.ok) begin
          // one more digit would not fit
          if (acc_i[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_o = PH_ERROR;
          end else begin
            acc_o  = {acc_i[SIZE_BITS-5:0], hex.value};
            seen_o = 1'b1;
          end
        end else if (byte_i == CH_SEMI) begin
          phase_o = PH_EXT;
        end else if (byte_i == CH_CR) begin
          phase_o = PH_LINE_CR;
        end else begin
          phase_o = PH_ERROR;
        end
      end
      PH_LINE_CR, PH_EXT_CR: begin
        if (byte_i == CH_LF) begin
          // end of size line
          if (!seen_i) begin
            phase_o = PH_ERROR;
          end else if (acc_i == '0) begin
            phase_o = PH_DONE;
          end else begin
            left_o  = acc_i;
            phase_o = PH_DATA;
          end
          acc_o     = '0;
          seen_o    = 1'b0;
          started_o = 1'b0;
        end else if (phase_i == PH_EXT_CR && byte_i != CH_CR) begin
          phase_o = PH_EXT;
        end else if (phase_i == PH_LINE_CR) begin
          phase_o = PH_ERROR;
        end
      end
      PH_EXT: begin
        if (byte_i == CH_CR) phase_o = PH_EXT_CR;
      end
      PH_DATA: begin
        res_o.data_valid = 1'b1;
        res_o.data_byte  = byte_i;
        left_o           = left_dec;
        if (left_dec == '0) phase_o = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        phase_o = (byte_i == CH_CR) ? PH_DATA_LF : PH_ERROR;
      end
      PH_DATA_LF: begin
        if (byte_i == CH_LF) begin
          phase_o   = PH_LINE;
          acc_o     = '0;
          seen_o    = 1'b0;
          started_o = 1'b0;
        end else begin
          phase_o = PH_ERROR;
        end
      end
      PH_DONE: begin
        phase_o = PH_DONE;
      end
      default: begin
        phase_o = PH_ERROR;
      end
    endcase

    if (phase_o == PH_ERROR) begin
      res_o.status = ST_ERROR;
    end else if (phase_o == PH_DONE) begin
      res_o.status = ST_COMPLETE;
    end

    // end of buffer: give the verdict and start afresh
    if (last_i) begin
      if (phase_o == PH_DONE || (phase_o == PH_LINE && !started_o)) begin
        res_o.status = ST_COMPLETE;
      end else begin
        res_o.status = ST_ERROR;
      end
      phase_o   = PH_LINE;
      acc_o     = '0;
      left_o    = '0;
      seen_o    = 1'b0;
      started_o = 1'b0;
    end
  end

endmodule

// ----- rtl/http_chunked_body_decoder.sv -----
// HTTP chunked body decoder: takes one body byte per request and returns one
// result per byte: the payload byte flag, the byte and the running status.
// The block accepts one byte every clock cycle while in_stall_o is low. The
// byte is captured in an input register; the parser step (hex size
// accumulate, down-count of the chunk bytes and the phase machine) then
// updates the state and loads the result register as the byte advances.
// Stall on the output backs up into the input register and then into
// in_stall_o, so no request is lost. Status 2 (error) is sticky until the
// byte flagged end_of_buffer, whose status is the verdict for the buffer;
// the parser then returns to the start of a size line. Sizes wider than
// SIZE_BITS bits are flagged as errors. Uses hcbd_pkg and hcbd_step.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   in_byte_i,
  input  logic                         end_of_buffer_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         data_valid_o,
  output logic [7:0]                   data_byte_o,
  output logic [hcbd_pkg::StatusW-1:0] status_o
);
  import hcbd_pkg::*;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // result register
  logic         out_valid_q, out_valid_d;
  hcbd_result_t res_q, res_d;

  // parser state
  logic [PhaseW-1:0]    phase_q, phase_d;
  logic [SIZE_BITS-1:0] acc_q, acc_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic                 seen_q, seen_d;
  logic                 started_q, started_d;

  logic out_free, s1_adv, s1_free, in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || s1_adv;
  assign in_stall_o = !s1_free;
  assign in_take    = in_valid_i && s1_free;

  assign s1_valid_d  = in_take || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  hcbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .phase_i  (phase_q),
    .acc_i    (acc_q),
    .left_i   (left_q),
    .seen_i   (seen_q),
    .started_i(started_q),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .phase_o  (phase_d),
    .acc_o    (acc_d),
    .left_o   (left_d),
    .seen_o   (seen_d),
    .started_o(started_d),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_LINE;
      acc_q       <= '0;
      left_q      <= '0;
      seen_q      <= 1'b0;
      started_q   <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        phase_q   <= phase_d;
        acc_q     <= acc_d;
        left_q    <= left_d;
        seen_q    <= seen_d;
        started_q <= started_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= end_of_buffer_i;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_valid_o = res_q.data_valid;
  assign data_byte_o  = res_q.data_byte;
  assign status_o     = res_q.status;

`ifndef SYNTHESIS
  // a payload byte never comes with the complete verdict
  a_data_not_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && data_valid_o) |-> (status_o != ST_COMPLETE))
    else $error("payload byte reported with complete status");

  // input only stalls when both registers are full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // the last byte of a buffer returns the parser to a fresh size line
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (phase_q == PH_LINE && !started_q && !seen_q))
    else $error("parser not restarted after end of buffer");
`endif

endmodule
